/* hdl/fixd_pkg.sv */
// ----------------------------------------------------------------------------
// fixd_pkg
// Shared constants, register indexes and state types of the fixation detector.
// ----------------------------------------------------------------------------
package fixd_pkg;

    // default field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // configuration port
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_VELOCITY_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DURATION   = 1'b1;

    localparam logic [CFG_W-1:0] VELOCITY_LIMIT_RST = 16'd0;
    localparam logic [CFG_W-1:0] MIN_DURATION_RST   = 16'd100;

    // width of a measured per-axis step (wider steps are always too far)
    localparam int STEP_W = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_COMPARE
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_START,
        B_DIV
    } back_state_t;

endpackage

/* hdl/fixd_fifo.sv */
// ----------------------------------------------------------------------------
// fixd_fifo
// Small register queue that decouples sample classification from run handling.
// ----------------------------------------------------------------------------
module fixd_fifo import fixd_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/fixd_front.sv */
// ----------------------------------------------------------------------------
// fixd_front
// Accepts gaze samples, measures the step from the previous sample and tags
// each sample as in or out of the velocity limit before queuing it.
// ----------------------------------------------------------------------------
module fixd_front import fixd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int ENTRY_W    = 2 * COORD_BITS + TIME_BITS + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_x,
    input  logic signed [COORD_BITS-1:0] s_y,
    input  logic        [TIME_BITS-1:0]  s_t,
    input  logic                         s_last,
    input  logic        [CFG_W-1:0]      velocity_limit,
    output logic                         q_push,
    output logic        [ENTRY_W-1:0]    q_data,
    input  logic                         q_full
);

    localparam int DIFF_W = (COORD_BITS + 1 > STEP_W) ? COORD_BITS + 1 : STEP_W;
    localparam int SQ_W   = 2 * STEP_W;

    front_state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                         have_prev_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic        [TIME_BITS-1:0]  t_reg;
    logic                         last_reg;
    logic                         first_reg;
    logic                         far_reg;
    logic        [STEP_W-1:0]     dx_reg, dy_reg;
    logic        [SQ_W-1:0]       sqx_reg, sqy_reg, lim2_reg;

    logic signed [DIFF_W-1:0] dfx, dfy;
    logic        [DIFF_W-1:0] adx, ady;
    logic                     far;
    logic                     step_ok;
    logic                     accept;

    assign accept = s_valid && s_ready;

    // absolute step per axis
    always_comb begin
        dfx = DIFF_W'(s_x) - DIFF_W'(prev_x_reg);
        dfy = DIFF_W'(s_y) - DIFF_W'(prev_y_reg);
        adx = dfx[DIFF_W-1] ? DIFF_W'(-dfx) : DIFF_W'(dfx);
        ady = dfy[DIFF_W-1] ? DIFF_W'(-dfy) : DIFF_W'(dfy);
        far = ((adx >> STEP_W) != '0) || ((ady >> STEP_W) != '0);
    end

    // squared step against squared limit; no previous sample counts as zero step
    assign step_ok = first_reg ||
                     (!far_reg && (({1'b0, sqx_reg} + {1'b0, sqy_reg}) <= {1'b0, lim2_reg}));

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = F_SQUARE;
                end
            end
            F_SQUARE: begin
                state_next = F_COMPARE;
            end
            F_COMPARE: begin
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_data = {last_reg, step_ok, t_reg, y_reg, x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // previous sample tracking; end of stream starts a fresh stream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end else if (accept) begin
            if (s_last) begin
                prev_x_reg    <= '0;
                prev_y_reg    <= '0;
                have_prev_reg <= 1'b0;
            end else begin
                prev_x_reg    <= s_x;
                prev_y_reg    <= s_y;
                have_prev_reg <= 1'b1;
            end
        end
    end

    // sample capture and squaring
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg     <= s_x;
            y_reg     <= s_y;
            t_reg     <= s_t;
            last_reg  <= s_last;
            first_reg <= !have_prev_reg;
            far_reg   <= far;
            dx_reg    <= adx[STEP_W-1:0];
            dy_reg    <= ady[STEP_W-1:0];
        end
        if (state_reg == F_SQUARE) begin
            sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            lim2_reg <= SQ_W'(velocity_limit) * SQ_W'(velocity_limit);
        end
    end

endmodule

/* hdl/fixd_div.sv */
// ----------------------------------------------------------------------------
// fixd_div
// Restoring divider, one quotient bit per cycle, signed dividend truncated
// toward zero, unsigned divisor.
// ----------------------------------------------------------------------------
module fixd_div import fixd_pkg::*; #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 16,
    parameter int Q_W   = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic        [DVS_W-1:0] divisor,
    output logic                    busy,
    output logic signed [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DVD_W-1:0] mag_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;
    logic [Q_W-1:0]   qmag;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, mag_reg[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    assign busy     = busy_reg;
    assign qmag     = mag_reg[Q_W-1:0];
    assign quotient = neg_reg ? Q_W'(-qmag) : qmag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend bits shift out at the top, quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DVD_W-1];
            mag_reg <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

endmodule

/* hdl/fixd_back.sv */
// ----------------------------------------------------------------------------
// fixd_back
// Builds runs from classified samples, closes them, checks count and span,
// and computes the centroid of each qualifying run for the result register.
// ----------------------------------------------------------------------------
module fixd_back import fixd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int ENTRY_W    = 2 * COORD_BITS + TIME_BITS + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  logic        [ENTRY_W-1:0]    q_data,
    output logic                         q_pop,
    input  logic        [CFG_W-1:0]      min_duration_ms,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] fix_x,
    output logic signed [COORD_BITS-1:0] fix_y,
    output logic        [TIME_BITS-1:0]  fix_start_ms,
    output logic        [TIME_BITS-1:0]  fix_duration_ms,
    output logic        [COUNT_BITS-1:0] fix_samples
);

    localparam int SUM_W = COORD_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    back_state_t state_reg, state_next;

    // open run
    logic                        run_open_reg;
    logic signed [SUM_W-1:0]     run_sum_x_reg, run_sum_y_reg;
    logic        [COUNT_BITS-1:0] run_count_reg;
    logic        [TIME_BITS-1:0] run_first_reg, run_last_reg;

    // closed run on its way through the dividers
    logic signed [SUM_W-1:0]      div_sx_reg, div_sy_reg;
    logic        [COUNT_BITS-1:0] div_n_reg;
    logic        [TIME_BITS-1:0]  hold_start_reg, hold_dur_reg;

    // result register
    logic                         m_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic        [TIME_BITS-1:0]  out_start_reg, out_dur_reg;
    logic        [COUNT_BITS-1:0] out_n_reg;

    // queue entry fields
    logic signed [COORD_BITS-1:0] e_x, e_y;
    logic        [TIME_BITS-1:0]  e_t;
    logic                         e_within, e_last;

    // run after this sample
    logic                         open_n;
    logic signed [SUM_W-1:0]      sum_x_n, sum_y_n;
    logic        [COUNT_BITS-1:0] count_n;
    logic        [TIME_BITS-1:0]  first_n, last_n, dur_n;
    logic                         close_run, qualify;

    logic                         take, load_out, div_start;
    logic                         busy_x, busy_y;
    logic signed [COORD_BITS-1:0] quot_x, quot_y;

    assign e_x      = q_data[COORD_BITS-1:0];
    assign e_y      = q_data[2*COORD_BITS-1:COORD_BITS];
    assign e_t      = q_data[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];
    assign e_within = q_data[2*COORD_BITS+TIME_BITS];
    assign e_last   = q_data[2*COORD_BITS+TIME_BITS+1];

    // run update and close decision
    always_comb begin
        open_n  = run_open_reg;
        sum_x_n = run_sum_x_reg;
        sum_y_n = run_sum_y_reg;
        count_n = run_count_reg;
        first_n = run_first_reg;
        last_n  = run_last_reg;
        if (e_within) begin
            open_n  = 1'b1;
            sum_x_n = run_sum_x_reg + SUM_W'(e_x);
            sum_y_n = run_sum_y_reg + SUM_W'(e_y);
            count_n = run_count_reg + 1'b1;
            first_n = run_open_reg ? run_first_reg : e_t;
            last_n  = e_t;
        end
        dur_n     = last_n - first_n;
        close_run = !e_within || (count_n == COUNT_MAX) || e_last;
        qualify   = open_n && (count_n >= COUNT_BITS'(2)) &&
                    (dur_n >= TIME_BITS'(min_duration_ms));
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        take       = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    take = 1'b1;
                    if (close_run && qualify) begin
                        state_next = B_START;
                    end
                end
            end
            B_START: begin
                div_start  = 1'b1;
                state_next = B_DIV;
            end
            B_DIV: begin
                if (!busy_x && !busy_y && (!m_valid_reg || m_ready)) begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign q_pop = take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // run registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg  <= 1'b0;
            run_sum_x_reg <= '0;
            run_sum_y_reg <= '0;
            run_count_reg <= '0;
            run_first_reg <= '0;
            run_last_reg  <= '0;
        end else if (take) begin
            if (close_run) begin
                run_open_reg  <= 1'b0;
                run_sum_x_reg <= '0;
                run_sum_y_reg <= '0;
                run_count_reg <= '0;
                run_first_reg <= '0;
                run_last_reg  <= '0;
            end else begin
                run_open_reg  <= open_n;
                run_sum_x_reg <= sum_x_n;
                run_sum_y_reg <= sum_y_n;
                run_count_reg <= count_n;
                run_first_reg <= first_n;
                run_last_reg  <= last_n;
            end
        end
    end

    // hold the closed run for the dividers
    always_ff @(posedge aclk) begin
        if (take && close_run && qualify) begin
            div_sx_reg     <= sum_x_n;
            div_sy_reg     <= sum_y_n;
            div_n_reg      <= count_n;
            hold_start_reg <= first_n;
            hold_dur_reg   <= dur_n;
        end
    end

    // centroid
    fixd_div #(
        .DVD_W (SUM_W),
        .DVS_W (COUNT_BITS),
        .Q_W   (COORD_BITS)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_sx_reg),
        .divisor  (div_n_reg),
        .busy     (busy_x),
        .quotient (quot_x)
    );

    fixd_div #(
        .DVD_W (SUM_W),
        .DVS_W (COUNT_BITS),
        .Q_W   (COORD_BITS)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_sy_reg),
        .divisor  (div_n_reg),
        .busy     (busy_y),
        .quotient (quot_y)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_x_reg     <= quot_x;
            out_y_reg     <= quot_y;
            out_start_reg <= hold_start_reg;
            out_dur_reg   <= hold_dur_reg;
            out_n_reg     <= div_n_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign fix_x           = out_x_reg;
    assign fix_y           = out_y_reg;
    assign fix_start_ms    = out_start_reg;
    assign fix_duration_ms = out_dur_reg;
    assign fix_samples     = out_n_reg;

`ifndef SYNTHESIS
    // a full run is always closed, never kept
    a_count_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        run_count_reg != COUNT_MAX)
        else $error("run count reached its maximum while held open");

    // a closed run leaves nothing behind
    a_closed_run_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_open_reg |-> (run_count_reg == '0))
        else $error("run count nonzero without an open run");

    // while a fixation is being finished the run is already cleared
    a_busy_run_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != B_IDLE) |-> !run_open_reg)
        else $error("run open while a fixation is in the divider");

    // a new result only comes out of the divide step
    a_result_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == B_DIV))
        else $error("result appeared outside the divide step");
`endif

endmodule

/* hdl/velocity_threshold_fixation_detect.sv */
// ----------------------------------------------------------------------------
// velocity_threshold_fixation_detect
// Velocity-threshold fixation detector: groups slow gaze samples into runs
// and reports qualifying runs as fixations with centroid, start and span.
// ----------------------------------------------------------------------------
// Usage:
//   Gaze samples enter on the s_ stream (x, y, time in tdata, end of stream
//   on tlast). Fixations leave on the m_ stream, at most one per sample.
//   velocity_limit and min_duration_ms are written through cfg_we/cfg_addr/
//   cfg_wdata while no sample is in flight.
// Flow:
//   The front takes one sample at a time through capture, square and
//   compare, and holds off the next until the current one is queued; a
//   4-entry queue sits between it and the run logic. A sample that emits
//   nothing leaves the back free to take the next queue entry. A sample
//   that closes a qualifying run occupies the back until the bit-serial
//   centroid dividers finish and the result register can take the result.
// Reset and stall:
//   aresetn (synchronous) empties the queue, closes any run, forgets the
//   previous sample and restores velocity_limit=0, min_duration_ms=100.
//   A stalled result waits in the output register; the back holds, the
//   queue fills and then s_tready drops. Nothing is dropped.
// ----------------------------------------------------------------------------
module velocity_threshold_fixation_detect import fixd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int S_DATA_W   = ((2 * COORD_BITS + TIME_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((2 * COORD_BITS + 2 * TIME_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // gaze_x, gaze_y, sample_time_ms
    input  logic                  s_tlast,   // end_of_stream
    // fixations
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // fix_x, fix_y, fix_start_ms,
                                             // fix_duration_ms, fix_samples
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int ENTRY_W = 2 * COORD_BITS + TIME_BITS + 2;

    logic [CFG_W-1:0] velocity_limit_reg;
    logic [CFG_W-1:0] min_duration_reg;

    logic signed [COORD_BITS-1:0] gaze_x, gaze_y;
    logic        [TIME_BITS-1:0]  sample_time_ms;

    logic               q_push, q_pop, q_full, q_empty;
    logic [ENTRY_W-1:0] q_din, q_dout;

    logic signed [COORD_BITS-1:0] fix_x, fix_y;
    logic        [TIME_BITS-1:0]  fix_start_ms, fix_duration_ms;
    logic        [COUNT_BITS-1:0] fix_samples;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            velocity_limit_reg <= VELOCITY_LIMIT_RST;
            min_duration_reg   <= MIN_DURATION_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_VELOCITY_LIMIT: velocity_limit_reg <= cfg_wdata;
                REG_MIN_DURATION:   min_duration_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input unpacking
    assign gaze_x         = s_tdata[COORD_BITS-1:0];
    assign gaze_y         = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign sample_time_ms = s_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];

    fixd_front #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .s_x            (gaze_x),
        .s_y            (gaze_y),
        .s_t            (sample_time_ms),
        .s_last         (s_tlast),
        .velocity_limit (velocity_limit_reg),
        .q_push         (q_push),
        .q_data         (q_din),
        .q_full         (q_full)
    );

    fixd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    fixd_back #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_data          (q_dout),
        .q_pop           (q_pop),
        .min_duration_ms (min_duration_reg),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .fix_x           (fix_x),
        .fix_y           (fix_y),
        .fix_start_ms    (fix_start_ms),
        .fix_duration_ms (fix_duration_ms),
        .fix_samples     (fix_samples)
    );

    // output packing, zero padded to whole bytes
    assign m_tdata = M_DATA_W'({fix_samples, fix_duration_ms, fix_start_ms, fix_y, fix_x});

endmodule

/* bench/tb_velocity_threshold_fixation_detect.sv */
// ----------------------------------------------------------------------------
// tb_velocity_threshold_fixation_detect
// Self-checking bench for the velocity-threshold fixation detector. Gaze
// samples are streamed in under random and directed patterns. A behavioral
// tracker in the bench groups them into runs and queues the fixations it
// expects. Every fixation that leaves the block is compared field by field
// with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_velocity_threshold_fixation_detect;
    import fixd_pkg::*;

    localparam int SETTLE_CYCLES = 80;     // latency plus queue depth, rounded up
    localparam int QUIET_LIMIT   = 5000;   // cycles without any transfer
    localparam int LONG_HOLD     = 600;    // receiver hold-off under pressure
    localparam int FULL_RUN      = 65535;  // run length that forces a close

    typedef struct {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [31:0] start_ms;
        logic [31:0] span_ms;
        logic [15:0] samples;
    } fixation_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;   // gaze_x, gaze_y, sample_time_ms
    logic         s_tlast   = 1'b0; // end_of_stream
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [111:0] m_tdata;          // fix_x, fix_y, fix_start_ms,
                                    // fix_duration_ms, fix_samples
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // tracker copy of the thresholds
    logic [15:0] lim_q4   = VELOCITY_LIMIT_RST;
    logic [15:0] min_span = MIN_DURATION_RST;

    // tracker copy of the run state
    logic signed [15:0] last_x     = '0;
    logic signed [15:0] last_y     = '0;
    logic               last_valid = 1'b0;
    logic               run_active = 1'b0;
    longint             acc_x      = 0;
    longint             acc_y      = 0;
    int                 acc_n      = 0;
    logic [31:0]        acc_t0     = '0;
    logic [31:0]        acc_t1     = '0;

    fixation_t fixation_q[$];

    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          rx_hold_len  = 0;
    int          fail_count   = 0;
    int          samples_sent = 0;
    int          quiet_cycles = 0;
    logic [31:0] now_ms       = '0;

    velocity_threshold_fixation_detect uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Tracker: close the open run, queue a fixation if it qualifies
    // ------------------------------------------------------------------
    function automatic void conclude_run();
        fixation_t   f;
        logic [31:0] span;
        span = acc_t1 - acc_t0;
        if (run_active && acc_n >= 2 && span >= {16'd0, min_span}) begin
            f.fx       = 16'(acc_x / longint'(acc_n));   // truncates toward zero
            f.fy       = 16'(acc_y / longint'(acc_n));
            f.start_ms = acc_t0;
            f.span_ms  = span;
            f.samples  = 16'(acc_n);
            fixation_q.insert(fixation_q.size(), f);
        end
        run_active = 1'b0;
        acc_x      = 0;
        acc_y      = 0;
        acc_n      = 0;
        acc_t0     = '0;
        acc_t1     = '0;
    endfunction

    // Tracker: fold one accepted sample into the run state
    function automatic void track_gaze(logic signed [15:0] x, logic signed [15:0] y,
                                       logic [31:0] t, logic eos);
        longint dx;
        longint dy;
        logic   in_limit;
        in_limit = 1'b1;
        if (last_valid) begin
            dx = longint'(x) - longint'(last_x);
            dy = longint'(y) - longint'(last_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > 65535 || dy > 65535)
                in_limit = 1'b0;
            else
                in_limit = (dx * dx + dy * dy) <= longint'(lim_q4) * longint'(lim_q4);
        end
        last_x     = x;
        last_y     = y;
        last_valid = 1'b1;

        if (in_limit) begin
            if (!run_active) begin
                run_active = 1'b1;
                acc_t0     = t;
            end
            acc_x  = acc_x + x;
            acc_y  = acc_y + y;
            acc_n  = acc_n + 1;
            acc_t1 = t;
            // a full run is flushed at once
            if (acc_n >= FULL_RUN) conclude_run();
        end else begin
            conclude_run();
        end

        // end of stream: flush and forget the previous sample
        if (eos) begin
            if (run_active) conclude_run();
            last_valid = 1'b0;
            last_x     = '0;
            last_y     = '0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        fixation_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (fixation_q.size() == 0) begin
                $error("fixation transfer with no expected fixation pending");
                fail_count++;
            end else begin
                want = fixation_q.pop_front();
                check_field("fix_x",           {16'd0, want.fx},      {16'd0, m_tdata[15:0]});
                check_field("fix_y",           {16'd0, want.fy},      {16'd0, m_tdata[31:16]});
                check_field("fix_start_ms",    want.start_ms,         m_tdata[63:32]);
                check_field("fix_duration_ms", want.span_ms,          m_tdata[95:64]);
                check_field("fix_samples",     {16'd0, want.samples}, {16'd0, m_tdata[111:96]});
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (rx_hold_len > 0) begin
            rx_hold_len = rx_hold_len - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("velocity_threshold_fixation_detect verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    // Offer one sample, with random idle cycles ahead of it
    task automatic offer_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic [31:0] t, input logic eos);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t, y, x};
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        track_gaze(x, y, t, eos);
        samples_sent++;
    endtask

    // Stop offering and wait until every expected fixation has left
    task automatic drain();
        s_tvalid <= 1'b0;
        while (fixation_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [15:0] lim, input logic [15:0] dur);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_VELOCITY_LIMIT;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_addr  <= REG_MIN_DURATION;
        cfg_wdata <= dur;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        lim_q4   = lim;
        min_span = dur;
    endtask

    // One fixation-like burst around a random center, maybe ended by end of stream
    task automatic gaze_burst();
        int cx;
        int cy;
        int j;
        int len;
        cx  = int'($urandom_range(60000)) - 30000;
        cy  = int'($urandom_range(60000)) - 30000;
        j   = ($urandom_range(3) == 0) ? lim_q4 / 2 : lim_q4 / 3;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0)
                now_ms = 32'hFFFF_FFFF - $urandom_range(200);
            else
                now_ms = now_ms + $urandom_range(1, 40);
            offer_sample(16'(cx + int'($urandom_range(2 * j)) - j),
                         16'(cy + int'($urandom_range(2 * j)) - j),
                         now_ms, (i == len - 1) && ($urandom_range(9) < 3));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset thresholds: limit 0 needs identical positions, span of 100 ms
    task automatic test_reset_thresholds();
        offer_sample(16'sd100, 16'sd200, 32'd1000, 1'b0);
        offer_sample(16'sd100, 16'sd200, 32'd1050, 1'b0);
        offer_sample(16'sd100, 16'sd200, 32'd1100, 1'b1);   // span exactly at minimum
        offer_sample(16'sd5, 16'sd5, 32'd0, 1'b0);
        offer_sample(16'sd5, 16'sd5, 32'd99, 1'b1);          // too short in time
        offer_sample(16'sd7, 16'sd7, 32'd500, 1'b1);         // single sample run
        offer_sample(16'sd0, 16'sd0, 32'd0, 1'b0);
        offer_sample(16'sd1, 16'sd0, 32'd200, 1'b0);         // step 1 over limit 0
        offer_sample(16'sd1, 16'sd0, 32'd300, 1'b1);
    endtask

    // Field extremes, timestamp wrap, rounding toward zero, limit boundary
    task automatic test_extremes();
        set_thresholds(16'hFFFF, 16'd0);
        offer_sample(-16'sd32768, -16'sd32768, 32'd0, 1'b0);
        offer_sample(16'sd32767, 16'sd32767, 32'hFFFF_FFFF, 1'b0);  // step over any limit
        offer_sample(16'sd32767, -16'sd32768, 32'hFFFF_FFF0, 1'b1);
        offer_sample(16'sd32767, -16'sd32768, 32'hFFFF_FFF0, 1'b0);
        offer_sample(16'sd32767, -16'sd32768, 32'h0000_0010, 1'b1); // span wraps
        offer_sample(-16'sd1, -16'sd3, 32'd100, 1'b0);
        offer_sample(16'sd0, 16'sd0, 32'd100, 1'b1);                // negative means

        set_thresholds(16'd5, 16'hFFFF);
        offer_sample(16'sd0, 16'sd0, 32'd1000, 1'b0);
        offer_sample(16'sd3, 16'sd4, 32'd66535, 1'b1);              // step exactly at limit
        offer_sample(16'sd0, 16'sd0, 32'd1000, 1'b0);
        offer_sample(16'sd3, 16'sd4, 32'd66534, 1'b1);              // one ms short
        offer_sample(16'sd0, 16'sd0, 32'd0, 1'b0);
        offer_sample(16'sd3, 16'sd5, 32'd10, 1'b0);                 // just over limit
        offer_sample(16'sd3, 16'sd5, 32'd20, 1'b0);
        offer_sample(16'sd3, 16'sd5, 32'd65555, 1'b1);
    endtask

    // Blocked receiver fills the block; then the sender waits for all results
    task automatic test_backpressure();
        int cx;
        int cy;
        set_thresholds(16'd50, 16'd10);
        rx_hold_len = LONG_HOLD;
        for (int i = 0; i < 24; i++) begin
            if (i == 16) drain();
            cx = int'($urandom_range(60000)) - 30000;
            cy = int'($urandom_range(60000)) - 30000;
            now_ms = now_ms + 100;
            offer_sample(16'(cx), 16'(cy), now_ms, 1'b0);
            offer_sample(16'(cx + 3), 16'(cy - 2), now_ms + 20, 1'b1);
        end
    endtask

    // Bursts with random content and some noise under one idle setting
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_samples);
        int stop_at;
        set_thresholds(16'($urandom_range(16, 800)), 16'($urandom_range(0, 150)));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        now_ms  = $urandom;
        stop_at = samples_sent + n_samples;
        while (samples_sent < stop_at) begin
            if ($urandom_range(99) < 20)
                offer_sample(16'($urandom), 16'($urandom), $urandom, 1'($urandom));
            else
                gaze_burst();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 17;
        rx_idle_pct = 87;

        test_reset_thresholds();
        test_extremes();
        test_random_traffic(17, 87, 125);
        test_random_traffic(87, 17, 125);
        test_backpressure();
        test_random_traffic(0, 0, 125);

        drain();
        if (fail_count == 0)
            $display("velocity_threshold_fixation_detect verification clean");
        else
            $display("velocity_threshold_fixation_detect verification failed");
        $finish;
    end

endmodule
